@@ rtl/mpld_pkg.sv @@
// Package for the max point-to-line distance block.
// Holds fixed widths, output limits and configuration register codes.
// No dependencies.
package mpld_pkg;

  localparam int QUO_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int OUT_W      = 21;
  localparam int CFG_ADDR_W = 5;
  localparam int PDATA_W    = 32;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [2:0] {
    REG_LINE_START_X = 3'd0,
    REG_LINE_START_Y = 3'd1,
    REG_LINE_START_Z = 3'd2,
    REG_LINE_END_X   = 3'd3,
    REG_LINE_END_Y   = 3'd4,
    REG_LINE_END_Z   = 3'd5
  } cfg_reg_t;

endpackage

@@ rtl/mpld_point_if.sv @@
// Point channel: valid/ready handshake with one 3D point per transfer.
// No dependencies.
interface mpld_point_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         last_point;

  modport source(output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink(input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

@@ rtl/mpld_result_if.sv @@
// Result channel: valid/ready handshake with one distance result per transfer.
// Depends on mpld_pkg.
interface mpld_result_if import mpld_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] max_distance;
  logic             degenerate_line;

  modport source(output valid, max_distance, degenerate_line, input ready);
  modport sink(input valid, max_distance, degenerate_line, output ready);
endinterface

@@ rtl/mpld_div.sv @@
// Restoring divider, one quotient bit per cycle: floor(num * 2^(2*FRAC_BITS) / den).
// Quotient keeps the low QUO_W bits. Depends on mpld_pkg.
module mpld_div import mpld_pkg::*; #(
  parameter int NUM_W     = 52,
  parameter int DEN_W     = 26,
  parameter int FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             done
);

  localparam int STEPS = NUM_W + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] diff;
  logic             fit;

  assign shifted = {rem_r, num_r[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign fit     = !diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        rem_r <= fit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], fit};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

@@ rtl/mpld_sqrt.sv @@
// Bit-pair integer square root of a QUO_W-bit radicand, one root bit per cycle.
// Depends on mpld_pkg.
module mpld_sqrt import mpld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [QUO_W-1:0]  rad,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  localparam int STEPS = QUO_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic [QUO_W-1:0] BIT_INIT = {2'b01, {(QUO_W-2){1'b0}}};

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [QUO_W-1:0] q_r;
  logic [QUO_W-1:0] res_r;
  logic [QUO_W-1:0] bit_r;

  logic [QUO_W-1:0] trial;
  logic [QUO_W:0]   diff;
  logic             fit;

  // res and bit never overlap, so res + bit is an OR
  assign trial = res_r | bit_r;
  assign diff  = {1'b0, q_r} - {1'b0, trial};
  assign fit   = !diff[QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
        q_r    <= rad;
        res_r  <= '0;
        bit_r  <= BIT_INIT;
      end else if (busy_r) begin
        if (fit) begin
          q_r   <= diff[QUO_W-1:0];
          res_r <= (res_r >> 1) | bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = res_r[ROOT_W-1:0];
  assign done = done_r;

endmodule

@@ rtl/max_point_line_distance.sv @@
// Greatest distance from a set of 3D points to the line through two configured
// endpoints. Each point is taken in ST_IDLE and then runs 11 steps through a
// single shared signed multiplier (six cross-product terms, three squares, and
// the compare into the set maximum); a point that is not the last of its set
// then returns to ST_IDLE. The last point also squares the line direction (two
// more multiplier steps), then, unless the endpoints coincide, runs the restoring
// divider and the square-root unit before its result is loaded into the output
// register. The output register holds a result until it is taken while the next
// point is accepted. No input is taken while a point is in flight. Line endpoints
// are written over the APB port at byte address 4*index and read back
// sign-extended.
// Depends on mpld_pkg, mpld_point_if, mpld_result_if, mpld_div, mpld_sqrt.
module max_point_line_distance import mpld_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready,
  mpld_point_if.sink            in_pt,
  mpld_result_if.source         out_res
);

  localparam int DW    = COORD_BITS + 1;
  localparam int CW    = 2 * DW;
  localparam int NW    = (2 * CW > QUO_W) ? QUO_W : 2 * CW;
  localparam int DEN_W = CW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } state_t;

  function automatic logic signed [DW-1:0] sxd(input logic [COORD_BITS-1:0] v);
    return {v[COORD_BITS-1], v};
  endfunction

  function automatic logic signed [CW-1:0] sxc(input logic signed [DW-1:0] v);
    return {{(CW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic [PDATA_W-1:0] sx32(input logic [COORD_BITS-1:0] v);
    return {{(PDATA_W-COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  state_t                  state_r;
  logic [3:0]              step_r;
  logic                    last_r;
  logic [COORD_BITS-1:0]   line_start_r [3];
  logic [COORD_BITS-1:0]   line_end_r [3];
  logic signed [DW-1:0]    ap_r [3];
  logic signed [DW-1:0]    ab_r [3];
  logic signed [CW-1:0]    cr_r [3];
  logic signed [CW-1:0]    cacc_r;
  logic signed [2*CW-1:0]  prod_r;
  logic [NW-1:0]           sacc_r;
  logic [DEN_W-1:0]        dacc_r;
  logic [NW-1:0]           set_max_r;
  logic [OUT_W-1:0]        stored_r;
  logic                    div_start_r;
  logic                    sqrt_start_r;
  logic [OUT_W-1:0]        res_dist_r;
  logic                    res_deg_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_dist_r;
  logic                    out_deg_r;

  logic [COORD_BITS-1:0]   pt [3];
  logic signed [CW-1:0]    opa;
  logic signed [CW-1:0]    opb;
  logic signed [2*CW-1:0]  prod_nxt;
  logic signed [CW-1:0]    cross_term;
  logic [NW-1:0]           sq_term;
  logic [DEN_W-1:0]        den_term;
  logic [QUO_W-1:0]        div_quo;
  logic                    div_done;
  logic [ROOT_W-1:0]       sqrt_root;
  logic                    sqrt_done;
  logic [OUT_W-1:0]        dist_cand;
  logic [OUT_W-1:0]        dist_nxt;
  logic                    cfg_wr;
  cfg_reg_t                cfg_idx;

  assign pt[0] = in_pt.point_x;
  assign pt[1] = in_pt.point_y;
  assign pt[2] = in_pt.point_z;

  // APB
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_LINE_START_X: prdata = sx32(line_start_r[0]);
      REG_LINE_START_Y: prdata = sx32(line_start_r[1]);
      REG_LINE_START_Z: prdata = sx32(line_start_r[2]);
      REG_LINE_END_X:   prdata = sx32(line_end_r[0]);
      REG_LINE_END_Y:   prdata = sx32(line_end_r[1]);
      REG_LINE_END_Z:   prdata = sx32(line_end_r[2]);
      default:          prdata = '0;
    endcase
  end

  // shared multiplier operand schedule
  always_comb begin
    case (step_r)
      4'd0:    begin opa = sxc(ap_r[1]); opb = sxc(ab_r[2]); end
      4'd1:    begin opa = sxc(ap_r[2]); opb = sxc(ab_r[1]); end
      4'd2:    begin opa = sxc(ap_r[2]); opb = sxc(ab_r[0]); end
      4'd3:    begin opa = sxc(ap_r[0]); opb = sxc(ab_r[2]); end
      4'd4:    begin opa = sxc(ap_r[0]); opb = sxc(ab_r[1]); end
      4'd5:    begin opa = sxc(ap_r[1]); opb = sxc(ab_r[0]); end
      4'd6:    begin opa = cr_r[0];      opb = cr_r[0];      end
      4'd7:    begin opa = cr_r[1];      opb = cr_r[1];      end
      4'd8:    begin opa = cr_r[2];      opb = cr_r[2];      end
      4'd9:    begin opa = sxc(ab_r[0]); opb = sxc(ab_r[0]); end
      4'd10:   begin opa = sxc(ab_r[1]); opb = sxc(ab_r[1]); end
      4'd11:   begin opa = sxc(ab_r[2]); opb = sxc(ab_r[2]); end
      default: begin opa = sxc(ap_r[0]); opb = sxc(ab_r[0]); end
    endcase
  end

  assign prod_nxt   = opa * opb;
  assign cross_term = $signed(prod_r[CW-1:0]);
  assign sq_term    = prod_r[NW-1:0];
  assign den_term   = prod_r[DEN_W-1:0];

  assign dist_cand = (|sqrt_root[ROOT_W-1:OUT_W]) ? OUT_MAX : sqrt_root[OUT_W-1:0];
  assign dist_nxt  = (dist_cand > stored_r) ? dist_cand : stored_r;

  mpld_div #(
    .NUM_W    (NW),
    .DEN_W    (DEN_W),
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start_r),
    .num  (set_max_r),
    .den  (dacc_r),
    .quo  (div_quo),
    .done (div_done)
  );

  mpld_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sqrt_start_r),
    .rad  (div_quo),
    .root (sqrt_root),
    .done (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      set_max_r    <= '0;
      stored_r     <= '0;
      for (int k = 0; k < 3; k++) begin
        line_start_r[k] <= '0;
        line_end_r[k]   <= '0;
      end
    end else begin
      div_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;

      if (cfg_wr) begin
        case (cfg_idx)
          REG_LINE_START_X: line_start_r[0] <= pwdata[COORD_BITS-1:0];
          REG_LINE_START_Y: line_start_r[1] <= pwdata[COORD_BITS-1:0];
          REG_LINE_START_Z: line_start_r[2] <= pwdata[COORD_BITS-1:0];
          REG_LINE_END_X:   line_end_r[0]   <= pwdata[COORD_BITS-1:0];
          REG_LINE_END_Y:   line_end_r[1]   <= pwdata[COORD_BITS-1:0];
          REG_LINE_END_Z:   line_end_r[2]   <= pwdata[COORD_BITS-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_res.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_pt.valid) begin
            for (int k = 0; k < 3; k++) begin
              ap_r[k] <= sxd(line_start_r[k]) - sxd(pt[k]);
              ab_r[k] <= sxd(line_start_r[k]) - sxd(line_end_r[k]);
            end
            last_r  <= in_pt.last_point;
            step_r  <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r <= prod_nxt;
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd1, 4'd3, 4'd5: cacc_r <= cross_term;
            4'd2:  cr_r[0] <= cacc_r - cross_term;
            4'd4:  cr_r[1] <= cacc_r - cross_term;
            4'd6:  cr_r[2] <= cacc_r - cross_term;
            4'd7:  sacc_r  <= sq_term;
            4'd8, 4'd9: sacc_r <= sacc_r + sq_term;
            4'd10: begin
              if (sacc_r > set_max_r) begin
                set_max_r <= sacc_r;
              end
              dacc_r <= den_term;
              if (!last_r) begin
                state_r <= ST_IDLE;
              end
            end
            4'd11: dacc_r <= dacc_r + den_term;
            4'd12: begin
              dacc_r  <= dacc_r + den_term;
              state_r <= ST_CHK;
            end
            default: ;
          endcase
        end
        ST_CHK: begin
          if (dacc_r == '0) begin
            // coincident endpoints: keep the running maximum
            set_max_r  <= '0;
            res_dist_r <= stored_r;
            res_deg_r  <= 1'b1;
            state_r    <= ST_FIN;
          end else begin
            div_start_r <= 1'b1;
            state_r     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            set_max_r    <= '0;
            sqrt_start_r <= 1'b1;
            state_r      <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            stored_r   <= dist_nxt;
            res_dist_r <= dist_nxt;
            res_deg_r  <= 1'b0;
            state_r    <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r <= 1'b1;
            out_dist_r  <= res_dist_r;
            out_deg_r   <= res_deg_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_pt.ready             = (state_r == ST_IDLE);
  assign out_res.valid           = out_valid_r;
  assign out_res.max_distance    = out_dist_r;
  assign out_res.degenerate_line = out_deg_r;

endmodule

@@ rtl/mpld_checker.sv @@
// Port-level checks for max_point_line_distance, attached by bind.
// Depends on mpld_pkg.
module mpld_checker import mpld_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] max_distance,
  input logic             degenerate_line
);

  logic [OUT_W-1:0] last_max_r;
  logic             out_xfer;

  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_max_r <= '0;
    end else if (out_xfer) begin
      last_max_r <= max_distance;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(max_distance) && $stable(degenerate_line))
    else $error("result changed while stalled");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a point is in flight");

  a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> max_distance >= last_max_r)
    else $error("running maximum decreased");

  a_degenerate_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && degenerate_line |-> max_distance == last_max_r)
    else $error("degenerate line changed the running maximum");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind max_point_line_distance mpld_checker u_mpld_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_pt.valid),
  .in_ready       (in_pt.ready),
  .out_valid      (out_res.valid),
  .out_ready      (out_res.ready),
  .max_distance   (out_res.max_distance),
  .degenerate_line(out_res.degenerate_line)
);

@@ test/tb_max_point_line_distance.sv @@
// Testbench for max_point_line_distance: streams point sets over the point channel,
// programs the line over APB and checks each result against an in-bench distance model.
// Depends on mpld_pkg, mpld_point_if, mpld_result_if and the RTL under rtl/.
module tb_max_point_line_distance import mpld_pkg::*; ();

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 8;
  localparam int RANDOM_ITEMS = 1250;
  localparam int SETTLE       = 150;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [OUT_W-1:0] distance;
    logic             degen;
  } dist_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [PDATA_W-1:0]    pwdata;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  mpld_point_if #(.COORD_BITS(COORD_BITS)) in_pt();
  mpld_result_if out_res();

  max_point_line_distance #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_pt  (in_pt),
    .out_res(out_res)
  );

  // distance model state
  coord_t           line_a [3] = '{default: '0};
  coord_t           line_b [3] = '{default: '0};
  logic [63:0]      set_peak_cross = '0;
  logic [OUT_W-1:0] running_peak = '0;
  dist_result_t     pending_results [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  random_sent = 0;
  bit  no_idle = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_results.size());
      $display("tb_max_point_line_distance: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    dist_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result dist=%0d degen=%0b",
                                  out_res.max_distance, out_res.degenerate_line));
      end else begin
        want = pending_results.pop_front();
        if (out_res.max_distance !== want.distance)
          report_mismatch($sformatf("max_distance got %0d exp %0d",
                                    out_res.max_distance, want.distance));
        if (out_res.degenerate_line !== want.degen)
          report_mismatch($sformatf("degenerate_line got %0b exp %0b",
                                    out_res.degenerate_line, want.degen));
      end
    end
  end

  function automatic void queue_expected(input dist_result_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic logic [63:0] abs_sq(input longint v);
    logic [63:0] m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] q);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= q) root = trial;
    end
    return root;
  endfunction

  function automatic void predict_point(input coord_t px, py, pz, input logic last);
    longint       ab [3];
    longint       ap [3];
    longint       cx, cy, cz;
    coord_t       p [3];
    logic [63:0]  cross_sq, len_sq, root;
    logic [127:0] scaled;
    dist_result_t res;
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int k = 0; k < 3; k++) begin
      ab[k] = longint'(line_a[k]) - longint'(line_b[k]);
      ap[k] = longint'(line_a[k]) - longint'(p[k]);
    end
    cx = ap[1] * ab[2] - ap[2] * ab[1];
    cy = ap[2] * ab[0] - ap[0] * ab[2];
    cz = ap[0] * ab[1] - ap[1] * ab[0];
    cross_sq = abs_sq(cx) + abs_sq(cy) + abs_sq(cz);
    if (cross_sq > set_peak_cross) set_peak_cross = cross_sq;
    if (last) begin
      len_sq = abs_sq(ab[0]) + abs_sq(ab[1]) + abs_sq(ab[2]);
      if (len_sq == 0) begin
        res.degen = 1'b1;
      end else begin
        scaled = {64'd0, set_peak_cross} << (2 * FRAC_BITS);
        scaled = scaled / {64'd0, len_sq};
        root = floor_sqrt(scaled[63:0]);
        if (root > 64'(OUT_MAX)) root = 64'(OUT_MAX);
        if (root > 64'(running_peak)) running_peak = root[OUT_W-1:0];
        res.degen = 1'b0;
      end
      res.distance = running_peak;
      queue_expected(res);
      set_peak_cross = '0;
    end
  endfunction

  task automatic send_point(input coord_t px, py, pz, input logic last);
    while (!no_idle && $urandom_range(99) < 22) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
    in_pt.valid      <= 1'b1;
    in_pt.point_x    <= px;
    in_pt.point_y    <= py;
    in_pt.point_z    <= pz;
    in_pt.last_point <= last;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
    predict_point(px, py, pz, last);
  endtask

  task automatic wait_idle();
    in_pt.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_line_reg(input cfg_reg_t r, input coord_t v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {{(PDATA_W-COORD_BITS){v[COORD_BITS-1]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_LINE_START_X: line_a[0] = v;
      REG_LINE_START_Y: line_a[1] = v;
      REG_LINE_START_Z: line_a[2] = v;
      REG_LINE_END_X:   line_b[0] = v;
      REG_LINE_END_Y:   line_b[1] = v;
      REG_LINE_END_Z:   line_b[2] = v;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_line(input coord_t ax, ay, az, bx, by, bz);
    wait_idle();
    write_line_reg(REG_LINE_START_X, ax);
    write_line_reg(REG_LINE_START_Y, ay);
    write_line_reg(REG_LINE_START_Z, az);
    write_line_reg(REG_LINE_END_X, bx);
    write_line_reg(REG_LINE_END_Y, by);
    write_line_reg(REG_LINE_END_Z, bz);
  endtask

  function automatic coord_t rand_coord(input int span);
    return coord_t'(int'($urandom_range(0, 2 * span - 1)) - span);
  endfunction

  // endpoints at reset coincide: degenerate
  task automatic test_reset_line();
    send_point(12'sd1, 12'sd2, 12'sd3, 1'b0);
    send_point(-12'sd1, -12'sd1, -12'sd1, 1'b1);
  endtask

  task automatic test_unit_lines();
    program_line(12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd0, 12'sd0);
    send_point(12'sd0, 12'sd3, 12'sd4, 1'b0);
    send_point(12'sd0, 12'sd1, 12'sd1, 1'b1);
    // smaller distance leaves the running max alone
    program_line(12'sd0, 12'sd0, 12'sd0, 12'sd3, 12'sd0, 12'sd0);
    send_point(12'sd0, 12'sd1, 12'sd0, 1'b1);
    send_point(12'sd2, 12'sd0, 12'sd0, 1'b1);
  endtask

  task automatic test_random_sets();
    int     phase;
    int     span;
    int     set_len;
    coord_t a [3];
    coord_t b [3];
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // coordinate span grows so the running max keeps moving
      span = 1 << ((2 + phase / 8 > 11) ? 11 : 2 + phase / 8);
      no_idle = (phase >= 30 && phase < 40);
      for (int k = 0; k < 3; k++) begin
        a[k] = rand_coord(span);
        b[k] = rand_coord(span);
      end
      case ($urandom_range(19))
        0: b = a;
        1, 2: begin
          b = a;
          b[$urandom_range(2)][0] ^= 1'b1;
        end
        default: ;
      endcase
      program_line(a[0], a[1], a[2], b[0], b[1], b[2]);
      for (int s = 0; s < 4; s++) begin
        set_len = ($urandom_range(9) == 0) ? 12 : $urandom_range(1, 5);
        for (int i = 0; i < set_len; i++) begin
          send_point(rand_coord(span), rand_coord(span), rand_coord(span),
                     i == set_len - 1);
          random_sent++;
        end
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_extreme_coords();
    program_line(-12'sd2048, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 12'sd2047);
    send_point(12'sd2047, -12'sd2048, -12'sd2048, 1'b0);
    send_point(-12'sd2048, 12'sd2047, 12'sd2047, 1'b0);
    send_point(12'sd0, 12'sd0, 12'sd0, 1'b1);
    // shortest line, farthest corner
    program_line(-12'sd2048, -12'sd2048, -12'sd2048, -12'sd2047, -12'sd2048, -12'sd2048);
    send_point(12'sd2047, 12'sd2047, 12'sd2047, 1'b1);
    send_point(-12'sd2048, -12'sd2048, -12'sd2048, 1'b1);
    program_line(12'sd2047, 12'sd2047, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048);
    send_point(-12'sd2048, -12'sd2048, 12'sd2047, 1'b1);
    program_line(12'sd2047, 12'sd0, 12'sd0, -12'sd2048, 12'sd0, 12'sd0);
    send_point(12'sd5, -12'sd1, 12'sd1, 1'b1);
  endtask

  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_pt.valid      = 1'b0;
    in_pt.point_x    = '0;
    in_pt.point_y    = '0;
    in_pt.point_z    = '0;
    in_pt.last_point = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_line();
    test_unit_lines();
    test_random_sets();
    test_extreme_coords();

    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_max_point_line_distance: PASS");
    end else begin
      $display("tb_max_point_line_distance: FAIL");
    end
    $finish;
  end

endmodule
